// ===== rtl/rom_image_payload_crc_identify_assert.svh =====
// Assertion macros used by ripci_back.
`ifndef ROM_IMAGE_PAYLOAD_CRC_IDENTIFY_ASSERT_SVH
`define ROM_IMAGE_PAYLOAD_CRC_IDENTIFY_ASSERT_SVH
`ifndef SYNTHESIS
// A property that must hold at every rising clock edge outside reset.
`define RIPCI_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// A condition that must never be seen outside reset.
`define RIPCI_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define RIPCI_ASSERT(lbl, clk, rst_n, prop, msg)
`define RIPCI_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/ripci_pkg.sv =====
`default_nettype none
package ripci_pkg;

	localparam int POS_W = 23;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
	localparam logic [POS_W-1:0] POS_PRG = POS_W'(4);
	localparam logic [POS_W-1:0] POS_CHR = POS_W'(5);
	localparam logic [POS_W-1:0] POS_FLAGS = POS_W'(6);
	localparam logic [POS_W-1:0] POS_MAGIC_END = POS_W'(4);
	localparam logic [POS_W-1:0] POS_HDR_LAST = POS_W'(15);

	localparam logic [9:0] HDR_LEN = 10'd16;
	localparam logic [9:0] HDR_TRAINER_LEN = 10'd528;
	localparam logic [7:0] TRAINER_MASK = 8'h04;

	localparam logic [3:0][7:0] MAGIC = {8'h1A, 8'h53, 8'h45, 8'h4E};

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
	localparam logic [31:0] PADDLE_CRC = 32'hD89E5A67;

	localparam logic [2:0][31:0] FAMICOM_GUN_LIST = {32'h2A6559A1, 32'h24598791, 32'h0AFB395E};
	localparam logic [2:0][31:0] TWO_ZAPPER_LIST = {32'hD15009CC, 32'hB79F2651, 32'h231BC76E};
	localparam logic [2:0][31:0] ONE_ZAPPER_LIST = {32'h051E60C6, 32'h04A6B46D, 32'h01B87025};

	typedef enum logic [1:0] {
		GUN_NONE = 2'd0,
		GUN_ZAPPER = 2'd1,
		GUN_FAMICOM = 2'd2,
		GUN_TWO_ZAPPERS = 2'd3
	} gun_mode_t;

	typedef struct packed {
		logic [7:0] image_byte;
		logic last_byte;
	} in_t;

	typedef struct packed {
		logic [31:0] payload_crc;
		logic image_valid;
		logic [1:0] gun_mode;
		logic [1:0] detected_mode;
		logic paddle_found;
	} out_t;

	// One classified byte on its way from the front to the back.
	typedef struct packed {
		logic [7:0] data;
		logic crc_en;
		logic last;
		logic valid;
	} entry_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic in_list(input logic [2:0][31:0] list, input logic [31:0] crc);
		return (list[0] == crc) || (list[1] == crc) || (list[2] == crc);
	endfunction

	function automatic gun_mode_t class_of(input logic [31:0] crc);
		gun_mode_t m;
		if (in_list(FAMICOM_GUN_LIST, crc)) begin
			m = GUN_FAMICOM;
		end else if (in_list(TWO_ZAPPER_LIST, crc)) begin
			m = GUN_TWO_ZAPPERS;
		end else if (in_list(ONE_ZAPPER_LIST, crc)) begin
			m = GUN_ZAPPER;
		end else begin
			m = GUN_NONE;
		end
		return m;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/ripci_front.sv =====
`default_nettype none
module ripci_front import ripci_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire in_t in_data,
	input wire logic full,
	output logic push,
	output entry_t push_entry
);

	logic [POS_W-1:0] pos_q;
	logic magic_good_q;
	logic [7:0] prg_q;
	logic [7:0] chr_q;
	logic trainer_q;
	logic [9:0] start_q;
	logic [POS_W-1:0] end_q;
	logic nonempty_q;

	logic [POS_W-1:0] payload_len;
	logic [POS_W:0] count;
	logic magic_bad;

	assign in_stall = full;
	assign push = in_valid && !full;

	assign payload_len = {1'b0, prg_q, 14'd0} + {2'b00, chr_q, 13'd0};
	assign count = {1'b0, pos_q} + (POS_W+1)'(1);
	assign magic_bad = (pos_q < POS_MAGIC_END) && (in_data.image_byte != MAGIC[pos_q[1:0]]);

	always_comb begin
		push_entry.data = in_data.image_byte;
		push_entry.last = in_data.last_byte;
		push_entry.crc_en = (pos_q >= {13'd0, start_q}) && (pos_q < end_q);
		// Header fields have long settled once the count reaches the header length.
		push_entry.valid = (pos_q >= POS_HDR_LAST) && magic_good_q && nonempty_q &&
			(count >= {1'b0, end_q});
	end

	// The span limits only matter from byte 16 on, so they are registered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= HDR_LEN;
			end_q <= '0;
			nonempty_q <= 1'b0;
		end else begin
			start_q <= trainer_q ? HDR_TRAINER_LEN : HDR_LEN;
			end_q <= payload_len + {13'd0, (trainer_q ? HDR_TRAINER_LEN : HDR_LEN)};
			nonempty_q <= (prg_q != 8'd0) || (chr_q != 8'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			magic_good_q <= 1'b1;
			prg_q <= '0;
			chr_q <= '0;
			trainer_q <= 1'b0;
		end else if (push) begin
			if (in_data.last_byte) begin
				pos_q <= '0;
				magic_good_q <= 1'b1;
				prg_q <= '0;
				chr_q <= '0;
				trainer_q <= 1'b0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + POS_W'(1);
				end
				if (magic_bad) begin
					magic_good_q <= 1'b0;
				end
				if (pos_q == POS_PRG) begin
					prg_q <= in_data.image_byte;
				end
				if (pos_q == POS_CHR) begin
					chr_q <= in_data.image_byte;
				end
				if (pos_q == POS_FLAGS) begin
					trainer_q <= (in_data.image_byte & TRAINER_MASK) != 8'd0;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ripci_queue.sv =====
`default_nettype none
module ripci_queue import ripci_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire entry_t push_entry,
	output logic full,
	input wire logic pop,
	output entry_t head_entry,
	output logic empty
);

	entry_t slots_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full = cnt_q == QCNT_W'(QDEPTH);
	assign empty = cnt_q == '0;
	assign head_entry = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + QCNT_W'(1);
				2'b01: cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ripci_back.sv =====
`default_nettype none
`include "rom_image_payload_crc_identify_assert.svh"
module ripci_back import ripci_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic cfg_data,
	input wire logic empty,
	input wire entry_t head_entry,
	output logic pop,
	output logic out_valid,
	input wire logic out_stall,
	output out_t out_data
);

	logic gun_enable_q;
	logic [31:0] crc_q;
	logic s1_valid_q;
	logic [31:0] crc_s1;
	logic good_s1;
	logic out_valid_q;
	out_t out_q;

	logic [31:0] crc_next;
	logic [31:0] crc_use;
	logic s1_move;
	logic s1_free;
	gun_mode_t det;

	assign crc_next = crc_byte(crc_q, head_entry.data);
	assign crc_use = head_entry.crc_en ? crc_next : crc_q;

	assign s1_move = s1_valid_q && (!out_valid_q || !out_stall);
	assign s1_free = !s1_valid_q || s1_move;
	// Ordinary bytes never wait; only the closing beat needs room in the result stage.
	assign pop = !empty && (!head_entry.last || s1_free);

	assign det = good_s1 ? class_of(crc_s1) : GUN_NONE;

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gun_enable_q <= 1'b1;
		end else if (cfg_write) begin
			gun_enable_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			s1_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				crc_q <= head_entry.last ? CRC_INIT : crc_use;
			end
			if (pop && head_entry.last) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_entry.last) begin
			crc_s1 <= head_entry.valid ? ~crc_use : 32'd0;
			good_s1 <= head_entry.valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_q.payload_crc <= crc_s1;
			out_q.image_valid <= good_s1;
			out_q.detected_mode <= det;
			out_q.gun_mode <= gun_enable_q ? det : GUN_NONE;
			out_q.paddle_found <= good_s1 && (crc_s1 == PADDLE_CRC);
		end
	end

	`RIPCI_ASSERT(a_invalid_clean, clk, arst_n, (out_valid_q && !out_q.image_valid) |-> (out_q.payload_crc == 32'd0 && out_q.detected_mode == GUN_NONE && !out_q.paddle_found), "invalid image reported with non-zero fields")
	`RIPCI_ASSERT(a_gun_gating, clk, arst_n, (out_valid_q && out_q.gun_mode != GUN_NONE) |-> (out_q.gun_mode == out_q.detected_mode), "gated gun mode differs from detected mode")
	`RIPCI_ASSERT(a_s1_holds, clk, arst_n, (s1_valid_q && !s1_move) |=> (s1_valid_q && $stable(crc_s1) && $stable(good_s1)), "pending result changed while blocked")
	`RIPCI_NEVER(a_last_overrun, clk, arst_n, pop && head_entry.last && s1_valid_q && !s1_move, "closing beat popped over a pending result")

endmodule
`default_nettype wire

// ===== rtl/rom_image_payload_crc_identify.sv =====
`default_nettype none
// Channel   Handshake             Payload
// input     in_valid / in_stall   in_data  (image_byte, last_byte)
// output    out_valid / out_stall out_data (payload_crc, image_valid, gun_mode,
//                                           detected_mode, paddle_found)
// config    cfg_write             cfg_data (gun_enable)
//
// One image byte is taken every cycle unless the byte queue is full; a beat flagged
// last yields one result. The closing beat passes through the byte queue, the s1
// result stage and the output register before out_valid rises.
// in_stall rises only when the four-entry byte queue is full.
// Reset clears the stream state and sets gun_enable to one.
module rom_image_payload_crc_identify import ripci_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire in_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output out_t out_data
);

	logic push;
	entry_t push_entry;
	logic full;
	logic pop;
	entry_t head_entry;
	logic empty;

	ripci_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.full(full),
		.push(push),
		.push_entry(push_entry)
	);

	ripci_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.full(full),
		.pop(pop),
		.head_entry(head_entry),
		.empty(empty)
	);

	ripci_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.empty(empty),
		.head_entry(head_entry),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule
`default_nettype wire

// ===== sim/rom_image_payload_crc_identify_tb.sv =====
`default_nettype none
module rom_image_payload_crc_identify_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ripci_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_PHASE_IMAGES = 25;

	localparam logic [31:0] REFLECTED_POLY = 32'hEDB88320;
	localparam logic [31:0] HEADER_BYTES = 32'd16;
	localparam logic [31:0] TRAINER_BYTES = 32'd512;
	localparam logic [31:0] PRG_BANK_BYTES = 32'd16384;
	localparam logic [31:0] CHR_BANK_BYTES = 32'd8192;
	localparam logic [3:0][7:0] IMAGE_MAGIC = {8'h1A, 8'h53, 8'h45, 8'h4E};

	localparam logic [2:0][31:0] FAMICOM_GUN_CRCS = {32'h2A6559A1, 32'h24598791, 32'h0AFB395E};
	localparam logic [2:0][31:0] TWO_ZAPPER_CRCS = {32'hD15009CC, 32'hB79F2651, 32'h231BC76E};
	localparam logic [2:0][31:0] ONE_ZAPPER_CRCS = {32'h051E60C6, 32'h04A6B46D, 32'h01B87025};
	localparam logic [31:0] PADDLE_TITLE_CRC = 32'hD89E5A67;

	class image_report_scoreboard;
		logic [22:0] byte_pos;
		logic [31:0] crc_reg;
		bit magic_ok;
		logic [7:0] prg_count;
		logic [7:0] chr_count;
		bit has_trainer;
		bit gun_enable;
		out_t expected_reports[$];
		int errors;

		function new();
			clear_stream();
			gun_enable = 1'b1;
			errors = 0;
		endfunction

		function void clear_stream();
			byte_pos = '0;
			crc_reg = '1;
			magic_ok = 1'b1;
			prg_count = '0;
			chr_count = '0;
			has_trainer = 1'b0;
		endfunction

		static function logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
			logic [31:0] c;
			c = crc ^ {24'd0, b};
			repeat (8) c = c[0] ? ((c >> 1) ^ REFLECTED_POLY) : (c >> 1);
			return c;
		endfunction

		// The lists are disjoint, but the famicom list wins if they ever overlap,
		// and the two-zapper list wins over the single zapper.
		static function gun_mode_t classify(logic [31:0] crc);
			gun_mode_t m;
			m = GUN_NONE;
			for (int k = 0; k < 3; k++) begin
				if (ONE_ZAPPER_CRCS[k] == crc) m = GUN_ZAPPER;
			end
			for (int k = 0; k < 3; k++) begin
				if (TWO_ZAPPER_CRCS[k] == crc) m = GUN_TWO_ZAPPERS;
			end
			for (int k = 0; k < 3; k++) begin
				if (FAMICOM_GUN_CRCS[k] == crc) m = GUN_FAMICOM;
			end
			return m;
		endfunction

		function void absorb_byte(in_t beat);
			logic [31:0] pos;
			logic [31:0] start;
			logic [31:0] span;
			logic [31:0] count;
			logic [31:0] crc;
			bit ok;
			out_t rep;
			pos = 32'(byte_pos);
			if (pos < 4 && beat.image_byte != IMAGE_MAGIC[pos[1:0]]) magic_ok = 1'b0;
			case (pos)
				4: prg_count = beat.image_byte;
				5: chr_count = beat.image_byte;
				6: has_trainer = beat.image_byte[2];
				default: ;
			endcase
			start = HEADER_BYTES + (has_trainer ? TRAINER_BYTES : 32'd0);
			span = prg_count * PRG_BANK_BYTES + chr_count * CHR_BANK_BYTES;
			if (pos >= start && pos < start + span) crc_reg = crc_step(crc_reg, beat.image_byte);
			if (byte_pos != '1) byte_pos++;
			if (beat.last_byte) begin
				count = pos + 1;
				ok = count >= HEADER_BYTES && magic_ok && span != 0 && count >= start + span;
				crc = ok ? ~crc_reg : 32'd0;
				rep.payload_crc = crc;
				rep.image_valid = ok;
				rep.detected_mode = ok ? classify(crc) : GUN_NONE;
				rep.gun_mode = gun_enable ? rep.detected_mode : GUN_NONE;
				rep.paddle_found = ok && crc == PADDLE_TITLE_CRC;
				expected_reports.push_back(rep);
				clear_stream();
			end
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_report(out_t got);
			out_t want;
			if (expected_reports.size() == 0) begin
				$display("%0t: result with none expected, expected nothing, actual crc %h valid %0d",
					$time, got.payload_crc, got.image_valid);
				errors++;
				return;
			end
			want = expected_reports.pop_front();
			compare("payload_crc", want.payload_crc, got.payload_crc);
			compare("image_valid", want.image_valid, got.image_valid);
			compare("gun_mode", want.gun_mode, got.gun_mode);
			compare("detected_mode", want.detected_mode, got.detected_mode);
			compare("paddle_found", want.paddle_found, got.paddle_found);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic cfg_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;

	image_report_scoreboard board = new();
	bit hold_request = 1'b0;
	int reports_seen = 0;

	rom_image_payload_crc_identify dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial begin : clock_gen
		forever #4 clk = ~clk;
	end

	// Runs the CRC register backwards over 32 zero-data shifts, so that four chosen
	// payload bytes can steer the final CRC onto any wanted value.
	function automatic logic [31:0] unwind_crc(logic [31:0] final_crc);
		logic [31:0] r;
		r = ~final_crc;
		repeat (32) r = r[31] ? (((r ^ REFLECTED_POLY) << 1) | 32'd1) : (r << 1);
		return r;
	endfunction

	function automatic void build_image(ref logic [7:0] img[$], input logic [7:0] prg,
			input logic [7:0] chr, input logic [7:0] flags, input int bad_magic,
			input bit forge, input logic [31:0] target, input bit to_end, input int extra);
		int pstart;
		int pend;
		int total;
		logic [31:0] crc;
		logic [31:0] word;
		logic [7:0] b;
		pstart = HEADER_BYTES + (flags[2] ? TRAINER_BYTES : 32'd0);
		pend = pstart + prg * PRG_BANK_BYTES + chr * CHR_BANK_BYTES;
		total = to_end ? pend + extra : extra;
		if (total < 1) total = 1;
		img.delete();
		crc = '1;
		word = '0;
		for (int i = 0; i < total; i++) begin
			b = 8'($urandom);
			if (i < 4) begin
				b = (i == bad_magic) ? IMAGE_MAGIC[i] ^ 8'($urandom_range(1, 255)) : IMAGE_MAGIC[i];
			end else if (i == 4) begin
				b = prg;
			end else if (i == 5) begin
				b = chr;
			end else if (i == 6) begin
				b = flags;
			end else if (i >= pstart && i < pend) begin
				if (forge && i == pend - 4) word = unwind_crc(target) ^ crc;
				if (forge && i >= pend - 4) b = word[8 * (i - (pend - 4)) +: 8];
				crc = image_report_scoreboard::crc_step(crc, b);
			end
			img.push_back(b);
		end
	endfunction

	function automatic logic [31:0] pick_target();
		int k;
		k = $urandom_range(0, 9);
		if (k < 3) return FAMICOM_GUN_CRCS[k];
		if (k < 6) return TWO_ZAPPER_CRCS[k - 3];
		if (k < 9) return ONE_ZAPPER_CRCS[k - 6];
		return PADDLE_TITLE_CRC;
	endfunction

	function automatic int sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_beat(input logic [7:0] b, input bit last, input int gap);
		in_t beat;
		beat.image_byte = b;
		beat.last_byte = last;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		do begin
			@(posedge clk);
		end while (in_stall);
		board.absorb_byte(beat);
		@(negedge clk);
	endtask

	task automatic send_image(input logic [7:0] img[$], input bit gapless);
		for (int i = 0; i < img.size(); i++) begin
			send_beat(img[i], i == img.size() - 1, gapless ? 0 : sender_gap());
		end
	endtask

	task automatic settle_and_set(input bit enable);
		in_valid <= 1'b0;
		while (board.expected_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_data <= enable;
		@(negedge clk);
		cfg_write <= 1'b0;
		board.gun_enable = enable;
	endtask

	task automatic run_directed();
		logic [7:0] img[$];
		img = {8'h00};
		send_image(img, 1'b1);
		img = {8'hFF};
		send_image(img, 1'b1);
		build_image(img, 8'd1, 8'd0, 8'h00, -1, 1'b0, '0, 1'b0, 15);
		send_image(img, 1'b1);
		// Header only, no banks at all.
		build_image(img, 8'd0, 8'd0, 8'h00, -1, 1'b0, '0, 1'b0, 16);
		send_image(img, 1'b1);
		build_image(img, 8'd255, 8'd255, 8'hFF, -1, 1'b0, '0, 1'b0, 40);
		send_image(img, 1'b0);
		for (int p = 0; p < 3; p++) begin
			build_image(img, 8'd1, 8'd0, 8'h00, p, 1'b0, '0, 1'b0, 20);
			send_image(img, 1'b0);
		end
		// Full length, but the last magic byte is wrong.
		build_image(img, 8'd0, 8'd1, 8'h00, 3, 1'b0, '0, 1'b1, 0);
		send_image(img, 1'b1);
		build_image(img, 8'd0, 8'd1, 8'h00, -1, 1'b1, FAMICOM_GUN_CRCS[0], 1'b1, 0);
		send_image(img, 1'b0);
		build_image(img, 8'd1, 8'd0, 8'h04, -1, 1'b1, TWO_ZAPPER_CRCS[1], 1'b1, 5);
		send_image(img, 1'b1);
		build_image(img, 8'd0, 8'd1, 8'hFB, -1, 1'b1, ONE_ZAPPER_CRCS[2], 1'b1, 0);
		send_image(img, 1'b0);
		build_image(img, 8'd0, 8'd1, 8'h00, -1, 1'b1, PADDLE_TITLE_CRC, 1'b1, 0);
		send_image(img, 1'b1);
		// Trainer present and the image one byte short of its payload.
		build_image(img, 8'd0, 8'd1, 8'h04, -1, 1'b0, '0, 1'b1, -1);
		send_image(img, 1'b1);
		build_image(img, 8'd1, 8'd1, 8'h00, -1, 1'b0, '0, 1'b1, 3);
		send_image(img, 1'b0);
	endtask

	task automatic run_random_phase(input int images);
		logic [7:0] img[$];
		logic [7:0] prg;
		logic [7:0] chr;
		logic [7:0] flags;
		int kind;
		int r;
		for (int n = 0; n < images; n++) begin
			kind = $urandom_range(0, 99);
			flags = 8'($urandom);
			if (kind < 17) begin
				r = $urandom_range(0, 99);
				prg = (r >= 70) ? 8'd1 : 8'd0;
				chr = (r < 85) ? 8'd1 : 8'd0;
				if (r >= 85) chr = 8'd1;
				flags[2] = ($urandom_range(0, 3) == 0);
				if (kind < 12) begin
					build_image(img, prg, chr, flags, -1, $urandom_range(0, 9) < 6, pick_target(),
						1'b1, ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 30));
				end else begin
					build_image(img, 8'd0, 8'd1, flags, -1, 1'b0, '0, 1'b1,
						-$urandom_range(1, 4));
				end
			end else if (kind < 50) begin
				build_image(img, 8'($urandom), 8'($urandom), flags, -1, 1'b0, '0, 1'b0,
					$urandom_range(1, 60));
			end else if (kind < 70) begin
				build_image(img, 8'($urandom), 8'($urandom), flags, $urandom_range(0, 3), 1'b0, '0,
					1'b0, $urandom_range(1, 60));
			end else if (kind < 88) begin
				build_image(img, 8'd0, 8'd0, flags, -1, 1'b0, '0, 1'b0, $urandom_range(1, 40));
				foreach (img[i]) img[i] = 8'($urandom);
			end else begin
				build_image(img, 8'd0, 8'd0, flags, -1, 1'b0, '0, 1'b0, $urandom_range(16, 40));
			end
			send_image(img, $urandom_range(0, 99) < 35);
		end
	endtask

	initial begin : stimulus
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_directed();
		settle_and_set(1'b0);
		run_random_phase(RANDOM_PHASE_IMAGES);
		settle_and_set(1'b1);
		run_random_phase(RANDOM_PHASE_IMAGES);
		settle_and_set(1'b0);
		run_random_phase(RANDOM_PHASE_IMAGES);
		settle_and_set(1'b1);
		run_random_phase(RANDOM_PHASE_IMAGES);
		in_valid <= 1'b0;
		while (board.expected_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Results are rare, so the long hold-offs are keyed to the result count: the
	// sender keeps offering beats until the byte queue fills and the input stalls.
	initial begin : receiver
		int span;
		int r;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				span = HOLD_OFF_CYCLES;
			end else begin
				r = $urandom_range(0, 9);
				if (r < 6) begin
					out_stall <= 1'b0;
					span = $urandom_range(1, 20);
				end else if (r < 9) begin
					out_stall <= 1'b1;
					span = $urandom_range(1, 3);
				end else begin
					out_stall <= 1'b1;
					span = $urandom_range(8, 40);
				end
			end
			repeat (span) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			board.check_report(out_data);
			reports_seen++;
			if (reports_seen == 1 || reports_seen == 40) hold_request = 1'b1;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire
